// ===== src/tlcs_pkg.sv =====
// Shared types, codes and constants of the tuner link control sequencer.
package tlcs_pkg;

    // Default count of DiSEqC slots walked per tune
    localparam int DISEQC_SLOTS_DEF = 4;

    // Configuration register indexes
    localparam int          CFG_IDX_W          = 3;
    localparam int          CFG_DATA_W         = 32;
    localparam logic [2:0]  CFG_CONNECT_ENABLE = 3'd0;
    localparam logic [2:0]  CFG_CLIENT_IP      = 3'd1;
    localparam logic [2:0]  CFG_CLIENT_PORT    = 3'd2;
    localparam logic [2:0]  CFG_PILOT_SETTING  = 3'd3;
    localparam logic [2:0]  CFG_DISEQC_TYPES   = 3'd4;

    // Event codes
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;
    localparam logic [1:0] MODE_LOAD  = 2'd3;

    // Response kinds
    localparam logic [3:0] RESP_CONNECT    = 4'd0;
    localparam logic [3:0] RESP_DISCONNECT = 4'd1;
    localparam logic [3:0] RESP_STOP       = 4'd2;
    localparam logic [3:0] RESP_FILTER     = 4'd3;
    localparam logic [3:0] RESP_STATUS     = 4'd4;
    localparam logic [3:0] RESP_TONE       = 4'd5;
    localparam logic [3:0] RESP_VOLTAGE    = 4'd6;
    localparam logic [3:0] RESP_FRONTEND   = 4'd7;
    localparam logic [3:0] RESP_START      = 4'd8;
    localparam logic [3:0] RESP_MASTER     = 4'd9;
    localparam logic [3:0] RESP_BURST      = 4'd10;

    // Request kinds
    localparam logic [3:0] REQ_CONNECT    = 4'd0;
    localparam logic [3:0] REQ_DISCONNECT = 4'd1;
    localparam logic [3:0] REQ_STOP       = 4'd2;
    localparam logic [3:0] REQ_SETFILT    = 4'd3;
    localparam logic [3:0] REQ_STATUS     = 4'd4;
    localparam logic [3:0] REQ_RSTFILT    = 4'd5;
    localparam logic [3:0] REQ_PREPTONE   = 4'd6;
    localparam logic [3:0] REQ_VOLTAGE    = 4'd7;
    localparam logic [3:0] REQ_TONE       = 4'd8;
    localparam logic [3:0] REQ_FRONTEND   = 4'd9;
    localparam logic [3:0] REQ_START      = 4'd10;
    localparam logic [3:0] REQ_MASTER     = 4'd11;
    localparam logic [3:0] REQ_BURST      = 4'd12;

    // DiSEqC slot types
    localparam logic [1:0] DTYPE_END    = 2'd0;
    localparam logic [1:0] DTYPE_MASTER = 2'd1;
    localparam logic [1:0] DTYPE_BURST  = 2'd2;

    // Pilot setting that asks for automatic detection
    localparam logic [1:0] PILOT_AUTO = 2'd2;

    // Flag bit positions
    localparam int FB_DO_TUNE   = 0;
    localparam int FB_STOP      = 1;
    localparam int FB_TUNED     = 2;
    localparam int FB_TRY_PILOT = 3;
    localparam int FB_HAVE_TUNE = 4;
    localparam int FB_SELECT    = 5;

    // Retry budgets and wait loads
    localparam logic [5:0] RETRY_NORMAL = 6'd10;
    localparam logic [5:0] RETRY_FILTER = 6'd50;
    localparam logic [5:0] RETRY_LOCKED = 6'd5;
    localparam logic [9:0] WAIT_FILTER  = 10'd5;
    localparam logic [9:0] WAIT_IDLE    = 10'd100;
    localparam logic [9:0] WAIT_LOCK    = 10'd1000;

    // Lock bit of the status word
    localparam int STATUS_LOCK_BIT = 4;

    typedef enum logic [4:0] {
        ST_DISC       = 5'd0,
        ST_SENT_CONN  = 5'd1,
        ST_CONN       = 5'd2,
        ST_SENT_DISC  = 5'd3,
        ST_SENT_STOP  = 5'd4,
        ST_SENT_FILT  = 5'd5,
        ST_SENT_STAT  = 5'd6,
        ST_SENT_RSTF  = 5'd7,
        ST_SENT_PREP  = 5'd8,
        ST_SENT_VOLT  = 5'd9,
        ST_DISEQC     = 5'd10,
        ST_SENT_MAST  = 5'd11,
        ST_SENT_BURST = 5'd12,
        ST_SENT_TONE  = 5'd13,
        ST_SENT_FE    = 5'd14,
        ST_SENT_START = 5'd15,
        ST_TUNING     = 5'd16,
        ST_ERROR      = 5'd17
    } t_state;

    typedef struct packed {
        logic        connect_enable;
        logic [31:0] client_ip;
        logic [15:0] client_port;
        logic [1:0]  pilot_setting;
        logic [7:0]  diseqc_types;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  mode;
        logic        pids_changed;
        logic        resp_valid;
        logic [3:0]  resp_for;
        logic        resp_bad;
        logic [15:0] resp_status;
        logic        send_ok;
    } t_item;

    typedef struct packed {
        logic       req_valid;
        logic [3:0] req_kind;
        logic       req_pilot;
        logic [1:0] req_slot;
        logic       reset_link;
        logic [4:0] link_state;
        logic       tuned;
    } t_result;

endpackage

// ===== src/tlcs_if.sv =====
// Channel interfaces: event items, result items and configuration writes.
interface tlcs_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic        pids_changed;
    logic        resp_valid;
    logic [3:0]  resp_for;
    logic        resp_bad;
    logic [15:0] resp_status;
    logic        send_ok;

    modport source (output valid, mode, pids_changed, resp_valid, resp_for, resp_bad,
                    resp_status, send_ok, input ready);
    modport sink   (input valid, mode, pids_changed, resp_valid, resp_for, resp_bad,
                    resp_status, send_ok, output ready);
endinterface

interface tlcs_result_if;
    logic       valid;
    logic       ready;
    logic       req_valid;
    logic [3:0] req_kind;
    logic       req_pilot;
    logic [1:0] req_slot;
    logic       reset_link;
    logic [4:0] link_state;
    logic       tuned;

    modport source (output valid, req_valid, req_kind, req_pilot, req_slot, reset_link,
                    link_state, tuned, input ready);
    modport sink   (input valid, req_valid, req_kind, req_pilot, req_slot, reset_link,
                    link_state, tuned, output ready);
endinterface

interface tlcs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/tlcs_cfg.sv =====
// Configuration register file of the sequencer.
module tlcs_cfg (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tlcs_cfg_if.sink       i_cfg,
    output tlcs_pkg::t_cfg o_cfg
);
    import tlcs_pkg::*;

    t_cfg r_cfg;
    logic wr;

    assign i_cfg.ready = 1'b1;
    assign wr          = i_cfg.valid && i_cfg.ready;
    assign o_cfg       = r_cfg;

    // Register write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr) begin
            unique case (i_cfg.index)
                CFG_CONNECT_ENABLE: r_cfg.connect_enable <= i_cfg.data[0];
                CFG_CLIENT_IP:      r_cfg.client_ip      <= i_cfg.data;
                CFG_CLIENT_PORT:    r_cfg.client_port    <= i_cfg.data[15:0];
                CFG_PILOT_SETTING:  r_cfg.pilot_setting  <= i_cfg.data[1:0];
                CFG_DISEQC_TYPES:   r_cfg.diseqc_types   <= i_cfg.data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== src/tlcs_fsm.sv =====
// Link state machine: state, counters and flags, updated once per item.
module tlcs_fsm #(
    parameter int DISEQC_SLOTS = tlcs_pkg::DISEQC_SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  tlcs_pkg::t_item   i_item,
    input  tlcs_pkg::t_cfg    i_cfg,
    output tlcs_pkg::t_result o_result
);
    import tlcs_pkg::*;

    localparam int SW = $clog2(DISEQC_SLOTS + 1);
    localparam logic [SW-1:0] SLOT_END = SW'(DISEQC_SLOTS);

    t_state        r_state, n_state;
    logic [5:0]    r_retry, n_retry;
    logic [9:0]    r_wait, n_wait;
    logic [SW-1:0] r_slot, n_slot;
    logic [5:0]    r_flags, n_flags;
    logic [1:0]    r_pilot, n_pilot;
    t_result       res;
    logic          do_tick;
    logic          live;
    logic          have_ip;
    logic [7:0]    slot8;
    logic [1:0]    dtype;

    function automatic logic got(t_item it, logic [3:0] kind);
        return it.resp_valid && !it.resp_bad && (it.resp_for == kind);
    endfunction

    assign have_ip = i_cfg.client_ip[31:24] != 8'd0;
    assign slot8   = 8'(r_slot);
    assign dtype   = (slot8 < 8'd4) ? i_cfg.diseqc_types[{slot8[1:0], 1'b0} +: 2] : DTYPE_END;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_DISC;
            r_retry <= '0;
            r_wait  <= '0;
            r_slot  <= '0;
            r_flags <= '0;
            r_pilot <= '0;
        end else if (i_fire) begin
            r_state <= n_state;
            r_retry <= n_retry;
            r_wait  <= n_wait;
            r_slot  <= n_slot;
            r_flags <= n_flags;
            r_pilot <= n_pilot;
        end
    end

    // Event handling, then one tick of the sequencer where the event calls for it
    always_comb begin
        n_state = r_state;
        n_retry = r_retry;
        n_wait  = r_wait;
        n_slot  = r_slot;
        n_flags = r_flags;
        n_pilot = r_pilot;
        res     = '0;
        do_tick = 1'b0;
        live    = (r_state != ST_DISC) && (r_state != ST_SENT_DISC);

        if (i_item.pids_changed) n_flags[FB_SELECT] = 1'b1;

        case (i_item.mode)
            MODE_TICK: do_tick = 1'b1;
            MODE_START: begin
                if (n_flags[FB_HAVE_TUNE]) begin
                    n_flags[FB_DO_TUNE] = 1'b1;
                    n_flags[FB_STOP]    = 1'b0;
                    if (live) begin
                        n_state = ST_CONN;
                        do_tick = 1'b1;
                    end
                end
            end
            MODE_STOP: begin
                n_flags[FB_DO_TUNE]   = 1'b0;
                n_flags[FB_HAVE_TUNE] = 1'b0;
                n_flags[FB_STOP]      = 1'b1;
                if (live) n_state = ST_CONN;
                do_tick = 1'b1;
            end
            default: begin
                n_flags[FB_HAVE_TUNE] = 1'b1;
                n_pilot               = i_cfg.pilot_setting;
            end
        endcase

        if (do_tick) begin
            unique case (n_state)
                ST_CONN: begin
                    if (!i_cfg.connect_enable) begin
                        if (have_ip) begin
                            res.req_valid = 1'b1;
                            res.req_kind  = REQ_DISCONNECT;
                        end
                        if (have_ip && i_item.send_ok) begin
                            n_state = ST_SENT_DISC;
                            n_retry = RETRY_NORMAL;
                        end else n_state = ST_ERROR;
                    end else if (n_flags[FB_DO_TUNE] || n_flags[FB_STOP]) begin
                        res.req_valid = 1'b1;
                        res.req_kind  = REQ_STOP;
                        if (i_item.send_ok) begin
                            n_state = ST_SENT_STOP;
                            n_retry = RETRY_NORMAL;
                        end else n_state = ST_ERROR;
                    end else if (n_flags[FB_SELECT]) begin
                        n_flags[FB_SELECT] = 1'b0;
                        res.req_valid      = 1'b1;
                        res.req_kind       = REQ_SETFILT;
                        if (i_item.send_ok) begin
                            n_state = ST_SENT_FILT;
                            n_retry = RETRY_FILTER;
                        end else n_state = ST_ERROR;
                    end else if (n_wait != '0) begin
                        n_wait = n_wait - 10'd1;
                    end else begin
                        res.req_valid = 1'b1;
                        res.req_kind  = REQ_STATUS;
                        if (i_item.send_ok) begin
                            n_state = ST_SENT_STAT;
                            n_retry = RETRY_NORMAL;
                        end else n_state = ST_ERROR;
                    end
                end
                ST_DISC: begin
                    if (i_cfg.connect_enable) begin
                        if (have_ip) begin
                            res.req_valid = 1'b1;
                            res.req_kind  = REQ_CONNECT;
                        end
                        if (have_ip && i_item.send_ok) begin
                            n_state = ST_SENT_CONN;
                            n_retry = RETRY_NORMAL;
                        end else n_state = ST_ERROR;
                    end
                end
                ST_DISEQC: begin
                    if (n_slot >= SLOT_END) begin
                        if (n_flags[FB_HAVE_TUNE]) begin
                            res.req_valid = 1'b1;
                            res.req_kind  = REQ_TONE;
                        end
                        if (n_flags[FB_HAVE_TUNE] && i_item.send_ok) begin
                            n_state = ST_SENT_TONE;
                            n_retry = RETRY_NORMAL;
                        end else n_state = ST_ERROR;
                    end else if (!n_flags[FB_HAVE_TUNE]) begin
                        n_state = ST_ERROR;
                    end else if (dtype == DTYPE_END) begin
                        n_slot = SLOT_END;
                    end else if (dtype == DTYPE_MASTER || dtype == DTYPE_BURST) begin
                        res.req_valid = 1'b1;
                        res.req_kind  = (dtype == DTYPE_MASTER) ? REQ_MASTER : REQ_BURST;
                        if (i_item.send_ok) begin
                            res.req_slot = slot8[1:0];
                            n_state = (dtype == DTYPE_MASTER) ? ST_SENT_MAST : ST_SENT_BURST;
                            n_retry = RETRY_NORMAL;
                            n_slot  = n_slot + SW'(1);
                        end else n_state = ST_ERROR;
                    end else begin
                        n_state = ST_ERROR;
                    end
                end
                ST_ERROR: begin
                    res.reset_link = 1'b1;
                    n_state        = ST_DISC;
                end
                ST_SENT_CONN: begin
                    if (got(i_item, RESP_CONNECT)) begin
                        if (n_flags[FB_HAVE_TUNE]) n_flags[FB_DO_TUNE] = 1'b1;
                        n_state = ST_CONN;
                    end else if (n_retry != '0) n_retry = n_retry - 6'd1;
                    else n_state = ST_ERROR;
                end
                ST_SENT_DISC: begin
                    n_state = got(i_item, RESP_DISCONNECT) ? ST_DISC : ST_ERROR;
                end
                ST_SENT_BURST, ST_SENT_MAST: begin
                    if (got(i_item, (n_state == ST_SENT_BURST) ? RESP_BURST : RESP_MASTER))
                        n_state = ST_DISEQC;
                    else if (n_retry != '0) n_retry = n_retry - 6'd1;
                    else n_state = ST_ERROR;
                end
                ST_SENT_STAT: begin
                    if (got(i_item, RESP_STATUS)) begin
                        n_state = ST_CONN;
                        n_wait  = WAIT_IDLE;
                    end else if (n_retry != '0) n_retry = n_retry - 6'd1;
                    else n_state = ST_ERROR;
                end
                ST_SENT_PREP: begin
                    if (got(i_item, RESP_TONE)) begin
                        if (n_flags[FB_HAVE_TUNE]) begin
                            res.req_valid = 1'b1;
                            res.req_kind  = REQ_VOLTAGE;
                        end
                        if (n_flags[FB_HAVE_TUNE] && i_item.send_ok) begin
                            n_state = ST_SENT_VOLT;
                            n_retry = RETRY_NORMAL;
                        end else n_state = ST_ERROR;
                    end else if (n_retry != '0) n_retry = n_retry - 6'd1;
                    else n_state = ST_ERROR;
                end
                ST_SENT_RSTF: begin
                    if (got(i_item, RESP_FILTER)) begin
                        if (n_flags[FB_HAVE_TUNE]) begin
                            res.req_valid = 1'b1;
                            res.req_kind  = REQ_PREPTONE;
                        end
                        if (n_flags[FB_HAVE_TUNE] && i_item.send_ok) begin
                            n_state = ST_SENT_PREP;
                            n_retry = RETRY_NORMAL;
                        end else n_state = ST_ERROR;
                    end else if (n_retry != '0) n_retry = n_retry - 6'd1;
                    else n_state = ST_ERROR;
                end
                ST_SENT_FILT: begin
                    if (got(i_item, RESP_FILTER)) begin
                        n_state = ST_CONN;
                        n_wait  = WAIT_FILTER;
                    end else if (n_retry != '0) n_retry = n_retry - 6'd1;
                    else n_state = ST_ERROR;
                end
                ST_SENT_FE: begin
                    if (got(i_item, RESP_FRONTEND)) begin
                        if (have_ip && i_cfg.client_port != '0) begin
                            res.req_valid = 1'b1;
                            res.req_kind  = REQ_START;
                        end
                        if (have_ip && i_cfg.client_port != '0 && i_item.send_ok) begin
                            n_state = ST_SENT_START;
                            n_retry = RETRY_NORMAL;
                        end else n_state = ST_ERROR;
                    end else if (n_retry != '0) n_retry = n_retry - 6'd1;
                    else n_state = ST_ERROR;
                end
                ST_SENT_TONE: begin
                    if (got(i_item, RESP_TONE)) begin
                        if (!n_flags[FB_HAVE_TUNE]) begin
                            n_state = ST_ERROR;
                        end else begin
                            // automatic pilot: first try without pilots
                            n_flags[FB_TRY_PILOT] = (n_pilot == PILOT_AUTO);
                            res.req_pilot = n_pilot[0];
                            res.req_valid = 1'b1;
                            res.req_kind  = REQ_FRONTEND;
                            if (i_item.send_ok) begin
                                n_state = ST_SENT_FE;
                                n_retry = RETRY_NORMAL;
                            end else n_state = ST_ERROR;
                        end
                    end else if (n_retry != '0) n_retry = n_retry - 6'd1;
                    else n_state = ST_ERROR;
                end
                ST_SENT_VOLT: begin
                    if (got(i_item, RESP_VOLTAGE)) begin
                        n_state = ST_DISEQC;
                        n_slot  = '0;
                    end else if (n_retry != '0) n_retry = n_retry - 6'd1;
                    else n_state = ST_ERROR;
                end
                ST_SENT_START: begin
                    if (got(i_item, RESP_START)) begin
                        res.req_valid = 1'b1;
                        res.req_kind  = REQ_STATUS;
                        if (i_item.send_ok) begin
                            n_state = ST_TUNING;
                            n_retry = RETRY_NORMAL;
                            n_wait  = WAIT_LOCK;
                        end else n_state = ST_ERROR;
                    end else if (n_retry != '0) n_retry = n_retry - 6'd1;
                    else n_state = ST_ERROR;
                end
                ST_SENT_STOP: begin
                    if (got(i_item, RESP_STOP)) begin
                        n_flags[FB_STOP]  = 1'b0;
                        n_flags[FB_TUNED] = 1'b0;
                        if (n_flags[FB_DO_TUNE]) begin
                            n_flags[FB_DO_TUNE] = 1'b0;
                            res.req_valid       = 1'b1;
                            res.req_kind        = REQ_RSTFILT;
                            if (i_item.send_ok) begin
                                n_state = ST_SENT_RSTF;
                                n_retry = RETRY_NORMAL;
                            end else n_state = ST_ERROR;
                        end else begin
                            n_state = ST_CONN;
                            n_wait  = WAIT_IDLE;
                        end
                    end else if (n_retry != '0) n_retry = n_retry - 6'd1;
                    else n_state = ST_ERROR;
                end
                ST_TUNING: begin
                    if (!got(i_item, RESP_STATUS)) begin
                        if (n_retry != '0) n_retry = n_retry - 6'd1;
                        else n_state = ST_ERROR;
                    end else if (i_item.resp_status[STATUS_LOCK_BIT]) begin
                        n_flags[FB_TUNED]  = 1'b1;
                        n_flags[FB_SELECT] = 1'b1;
                        res.req_valid      = 1'b1;
                        res.req_kind       = REQ_STATUS;
                        if (i_item.send_ok) begin
                            n_state = ST_SENT_STAT;
                            n_retry = RETRY_LOCKED;
                        end else n_state = ST_ERROR;
                    end else if (n_wait != '0) begin
                        n_wait        = n_wait - 10'd1;
                        res.req_valid = 1'b1;
                        res.req_kind  = REQ_STATUS;
                        if (i_item.send_ok) n_retry = RETRY_NORMAL;
                        else n_state = ST_ERROR;
                    end else if (n_flags[FB_TRY_PILOT] && n_flags[FB_HAVE_TUNE]) begin
                        // no lock without pilots: retune with pilots on
                        n_pilot               = 2'd1;
                        n_flags[FB_TRY_PILOT] = 1'b0;
                        res.req_pilot         = 1'b1;
                        res.req_valid         = 1'b1;
                        res.req_kind          = REQ_FRONTEND;
                        if (i_item.send_ok) begin
                            n_state = ST_SENT_FE;
                            n_retry = RETRY_NORMAL;
                        end else n_state = ST_ERROR;
                    end else begin
                        n_state = ST_ERROR;
                    end
                end
                default: n_state = ST_ERROR;
            endcase
        end

        res.link_state = n_state;
        res.tuned      = n_flags[FB_TUNED];
    end

    assign o_result = res;

`ifndef SYNTH
    a_error_recovers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && r_state == ST_ERROR && i_item.mode == MODE_TICK |=> r_state == ST_DISC)
        else $error("error state did not return to disconnected");
    a_retry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_retry <= RETRY_FILTER)
        else $error("retry counter above its largest load");
    a_wait_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wait <= WAIT_LOCK)
        else $error("wait counter above its largest load");
    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_END)
        else $error("slot index past the slot count");
    a_reset_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.reset_link |-> !res.req_valid && res.link_state == ST_DISC)
        else $error("link reset issued together with a request");
`endif

endmodule

// ===== src/tuner_link_control_sequencer.sv =====
// Top level of the tuner link control sequencer: item register, state machine, result register.
//
//  channel   | dir | handshake      | payload
//  ----------+-----+----------------+-------------------------------------------------
//  i_item    | in  | valid / ready  | mode, pids_changed, resp_*, send_ok
//  o_result  | out | valid / ready  | req_valid, req_kind, req_pilot, req_slot,
//            |     |                | reset_link, link_state, tuned
//  i_cfg     | in  | valid / ready  | index, data (ready always high)
//
// An item is captured in the input register, runs through the combinational state machine and
// lands in the result register. One item per cycle is sustained unless the result stalls;
// the state update sits in the single state machine step.
// Reset is synchronous and active low; the link starts disconnected, state and config registers zero.
// A stalled result holds the result register; an empty input register still takes one more item.
module tuner_link_control_sequencer #(
    parameter int DISEQC_SLOTS = tlcs_pkg::DISEQC_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlcs_item_if.sink   i_item,
    tlcs_result_if.source o_result,
    tlcs_cfg_if.sink    i_cfg
);
    import tlcs_pkg::*;

    t_item   r_item;
    logic    r_item_vld;
    t_result r_res;
    logic    r_res_vld;
    t_cfg    cfg;
    t_result step_res;
    logic    advance;
    logic    take;

    // Configuration registers
    tlcs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Sequencer step
    tlcs_fsm #(
        .DISEQC_SLOTS (DISEQC_SLOTS)
    ) u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (advance),
        .i_item   (r_item),
        .i_cfg    (cfg),
        .o_result (step_res)
    );

    // Handshake control
    assign advance      = r_item_vld && (!r_res_vld || o_result.ready);
    assign i_item.ready = !r_item_vld || advance;
    assign take         = i_item.valid && i_item.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_vld <= 1'b0;
        end else if (i_item.ready) begin
            r_item_vld <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item.mode         <= i_item.mode;
            r_item.pids_changed <= i_item.pids_changed;
            r_item.resp_valid   <= i_item.resp_valid;
            r_item.resp_for     <= i_item.resp_for;
            r_item.resp_bad     <= i_item.resp_bad;
            r_item.resp_status  <= i_item.resp_status;
            r_item.send_ok      <= i_item.send_ok;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else if (advance) begin
            r_res_vld <= 1'b1;
        end else if (o_result.ready) begin
            r_res_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= step_res;
        end
    end

    assign o_result.valid      = r_res_vld;
    assign o_result.req_valid  = r_res.req_valid;
    assign o_result.req_kind   = r_res.req_kind;
    assign o_result.req_pilot  = r_res.req_pilot;
    assign o_result.req_slot   = r_res.req_slot;
    assign o_result.reset_link = r_res.reset_link;
    assign o_result.link_state = r_res.link_state;
    assign o_result.tuned      = r_res.tuned;

endmodule

// ===== dv/tuner_link_control_sequencer_tb.sv =====
// Self-checking testbench for the tuner link control sequencer: predicted link steps vs results.
`timescale 1ns / 1ps

module tuner_link_control_sequencer_tb;
    import tlcs_pkg::*;

    localparam int SLOT_COUNT  = DISEQC_SLOTS_DEF;
    localparam int QUIET_LIMIT = 2000;

    typedef struct {
        t_item   ev;
        t_result res;
    } t_pending;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tlcs_item_if   event_ch();
    tlcs_result_if result_ch();
    tlcs_cfg_if    cfg_ch();

    tuner_link_control_sequencer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (event_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predicted link: register copy and sequencer state
    logic        cf_enable  = 1'b0;
    logic [31:0] cf_ip      = '0;
    logic [15:0] cf_port    = '0;
    logic [1:0]  cf_pilot   = '0;
    logic [7:0]  cf_dtypes  = '0;
    t_state      ln_state   = ST_DISC;
    logic [5:0]  ln_retry   = '0;
    logic [9:0]  ln_wait    = '0;
    logic [2:0]  ln_slot    = '0;
    logic [5:0]  ln_flags   = '0;
    logic [1:0]  ln_pilot   = '0;
    t_item       cur_in;
    t_result     step_out;

    // Stimulus and scoreboard bookkeeping
    t_pending pending_events[$];
    t_result  expected_results[$];
    t_result  offered_result;
    int       outstanding   = 0;
    int       errors        = 0;
    int       results_seen  = 0;
    int       send_idle_pct = 0;
    int       recv_idle_pct = 0;
    int       hold_left     = 0;
    bit       hold_done     = 1'b0;
    int       quiet_cycles  = 0;

    function automatic bit has_ip();
        return cf_ip[31:24] != 8'd0;
    endfunction

    function automatic bit has_tune();
        return ln_flags[FB_HAVE_TUNE];
    endfunction

    // Present a request; true when the transport takes it
    function automatic bit offer(logic [3:0] kind, bit pre);
        if (!pre)
            return 1'b0;
        step_out.req_valid = 1'b1;
        step_out.req_kind  = kind;
        return cur_in.send_ok;
    endfunction

    function automatic bit heard(logic [3:0] kind);
        return cur_in.resp_valid && !cur_in.resp_bad && cur_in.resp_for == kind;
    endfunction

    function automatic void go(t_state st, logic [5:0] retry);
        ln_state = st;
        ln_retry = retry;
    endfunction

    function automatic void send_go(logic [3:0] kind, bit pre, t_state st, logic [5:0] retry);
        if (offer(kind, pre))
            go(st, retry);
        else
            ln_state = ST_ERROR;
    endfunction

    function automatic void retry_or_fail();
        if (ln_retry != 0)
            ln_retry--;
        else
            ln_state = ST_ERROR;
    endfunction

    // Frontend request; automatic pilot tunes without pilots first and arms a retry
    function automatic bit offer_frontend();
        if (!has_tune())
            return 1'b0;
        ln_flags[FB_TRY_PILOT] = 1'b0;
        if (ln_pilot == PILOT_AUTO) begin
            step_out.req_pilot     = 1'b0;
            ln_flags[FB_TRY_PILOT] = 1'b1;
        end else begin
            step_out.req_pilot = (ln_pilot != 2'd0);
        end
        return offer(REQ_FRONTEND, 1'b1);
    endfunction

    // One evaluation of the sequencer
    function automatic void tick_link();
        logic [1:0] dtype;
        case (ln_state)
            ST_CONN: begin
                if (!cf_enable)
                    send_go(REQ_DISCONNECT, has_ip(), ST_SENT_DISC, RETRY_NORMAL);
                else if (ln_flags[FB_DO_TUNE] || ln_flags[FB_STOP])
                    send_go(REQ_STOP, 1'b1, ST_SENT_STOP, RETRY_NORMAL);
                else if (ln_flags[FB_SELECT]) begin
                    ln_flags[FB_SELECT] = 1'b0;
                    send_go(REQ_SETFILT, 1'b1, ST_SENT_FILT, RETRY_FILTER);
                end else if (ln_wait != 0)
                    ln_wait--;
                else
                    send_go(REQ_STATUS, 1'b1, ST_SENT_STAT, RETRY_NORMAL);
            end
            ST_DISC: begin
                if (cf_enable)
                    send_go(REQ_CONNECT, has_ip(), ST_SENT_CONN, RETRY_NORMAL);
            end
            ST_DISEQC: begin
                if (ln_slot >= SLOT_COUNT)
                    send_go(REQ_TONE, has_tune(), ST_SENT_TONE, RETRY_NORMAL);
                else if (!has_tune())
                    ln_state = ST_ERROR;
                else begin
                    // slots past the register read as end
                    dtype = (ln_slot < 3'd4) ? 2'(cf_dtypes >> (2 * ln_slot)) : DTYPE_END;
                    if (dtype == DTYPE_END)
                        ln_slot = 3'(SLOT_COUNT);
                    else if (dtype == DTYPE_MASTER || dtype == DTYPE_BURST) begin
                        step_out.req_slot = ln_slot[1:0];
                        if (offer(dtype == DTYPE_MASTER ? REQ_MASTER : REQ_BURST, 1'b1)) begin
                            go(dtype == DTYPE_MASTER ? ST_SENT_MAST : ST_SENT_BURST,
                               RETRY_NORMAL);
                            ln_slot++;
                        end else begin
                            step_out.req_slot = 2'd0;
                            ln_state          = ST_ERROR;
                        end
                    end else
                        ln_state = ST_ERROR;
                end
            end
            ST_ERROR: begin
                step_out.reset_link = 1'b1;
                ln_state            = ST_DISC;
            end
            ST_SENT_CONN: begin
                if (heard(RESP_CONNECT)) begin
                    if (has_tune())
                        ln_flags[FB_DO_TUNE] = 1'b1;
                    ln_state = ST_CONN;
                end else
                    retry_or_fail();
            end
            ST_SENT_DISC: ln_state = heard(RESP_DISCONNECT) ? ST_DISC : ST_ERROR;
            ST_SENT_BURST, ST_SENT_MAST: begin
                if (heard(ln_state == ST_SENT_BURST ? RESP_BURST : RESP_MASTER))
                    ln_state = ST_DISEQC;
                else
                    retry_or_fail();
            end
            ST_SENT_STAT: begin
                if (heard(RESP_STATUS)) begin
                    ln_state = ST_CONN;
                    ln_wait  = WAIT_IDLE;
                end else
                    retry_or_fail();
            end
            ST_SENT_PREP: begin
                if (heard(RESP_TONE))
                    send_go(REQ_VOLTAGE, has_tune(), ST_SENT_VOLT, RETRY_NORMAL);
                else
                    retry_or_fail();
            end
            ST_SENT_RSTF: begin
                if (heard(RESP_FILTER))
                    send_go(REQ_PREPTONE, has_tune(), ST_SENT_PREP, RETRY_NORMAL);
                else
                    retry_or_fail();
            end
            ST_SENT_FILT: begin
                if (heard(RESP_FILTER)) begin
                    ln_state = ST_CONN;
                    ln_wait  = WAIT_FILTER;
                end else
                    retry_or_fail();
            end
            ST_SENT_FE: begin
                if (heard(RESP_FRONTEND))
                    send_go(REQ_START, has_ip() && cf_port != 16'd0, ST_SENT_START,
                            RETRY_NORMAL);
                else
                    retry_or_fail();
            end
            ST_SENT_TONE: begin
                if (heard(RESP_TONE)) begin
                    if (offer_frontend())
                        go(ST_SENT_FE, RETRY_NORMAL);
                    else
                        ln_state = ST_ERROR;
                end else
                    retry_or_fail();
            end
            ST_SENT_VOLT: begin
                if (heard(RESP_VOLTAGE)) begin
                    ln_state = ST_DISEQC;
                    ln_slot  = 3'd0;
                end else
                    retry_or_fail();
            end
            ST_SENT_START: begin
                if (heard(RESP_START)) begin
                    if (offer(REQ_STATUS, 1'b1)) begin
                        go(ST_TUNING, RETRY_NORMAL);
                        ln_wait = WAIT_LOCK;
                    end else
                        ln_state = ST_ERROR;
                end else
                    retry_or_fail();
            end
            ST_SENT_STOP: begin
                if (heard(RESP_STOP)) begin
                    ln_flags[FB_STOP]  = 1'b0;
                    ln_flags[FB_TUNED] = 1'b0;
                    if (ln_flags[FB_DO_TUNE]) begin
                        ln_flags[FB_DO_TUNE] = 1'b0;
                        send_go(REQ_RSTFILT, 1'b1, ST_SENT_RSTF, RETRY_NORMAL);
                    end else begin
                        // plain stop answer settles in connected
                        ln_state = ST_CONN;
                        ln_wait  = WAIT_IDLE;
                    end
                end else
                    retry_or_fail();
            end
            ST_TUNING: begin
                if (!heard(RESP_STATUS))
                    retry_or_fail();
                else if (cur_in.resp_status[STATUS_LOCK_BIT]) begin
                    ln_flags[FB_TUNED]  = 1'b1;
                    ln_flags[FB_SELECT] = 1'b1;
                    send_go(REQ_STATUS, 1'b1, ST_SENT_STAT, RETRY_LOCKED);
                end else if (ln_wait != 0) begin
                    ln_wait--;
                    if (offer(REQ_STATUS, 1'b1))
                        ln_retry = RETRY_NORMAL;
                    else
                        ln_state = ST_ERROR;
                end else if (ln_flags[FB_TRY_PILOT] && has_tune()) begin
                    // no lock without pilots: retune with pilots
                    ln_pilot = 2'd1;
                    if (offer_frontend())
                        go(ST_SENT_FE, RETRY_NORMAL);
                    else
                        ln_state = ST_ERROR;
                end else
                    ln_state = ST_ERROR;
            end
            default: ln_state = ST_ERROR;
        endcase
    endfunction

    // Expected result of one event item; advances the predicted link
    function automatic t_result link_step(t_item ev);
        bit live;
        step_out = '0;
        cur_in   = ev;
        if (ev.pids_changed)
            ln_flags[FB_SELECT] = 1'b1;
        live = (ln_state != ST_DISC) && (ln_state != ST_SENT_DISC);
        case (ev.mode)
            MODE_TICK: tick_link();
            MODE_START: begin
                if (has_tune()) begin
                    ln_flags[FB_DO_TUNE] = 1'b1;
                    ln_flags[FB_STOP]    = 1'b0;
                    if (live) begin
                        ln_state = ST_CONN;
                        tick_link();
                    end
                end
            end
            MODE_STOP: begin
                ln_flags[FB_DO_TUNE]   = 1'b0;
                ln_flags[FB_HAVE_TUNE] = 1'b0;
                ln_flags[FB_STOP]      = 1'b1;
                if (live)
                    ln_state = ST_CONN;
                tick_link();
            end
            default: begin
                ln_flags[FB_HAVE_TUNE] = 1'b1;
                ln_pilot               = cf_pilot;
            end
        endcase
        step_out.link_state = ln_state;
        step_out.tuned      = ln_flags[FB_TUNED];
        return step_out;
    endfunction

    // Response kind the predicted link is waiting for
    function automatic logic [3:0] awaited_resp();
        case (ln_state)
            ST_SENT_CONN:               return RESP_CONNECT;
            ST_SENT_DISC:               return RESP_DISCONNECT;
            ST_SENT_STOP:               return RESP_STOP;
            ST_SENT_FILT, ST_SENT_RSTF: return RESP_FILTER;
            ST_SENT_STAT, ST_TUNING:    return RESP_STATUS;
            ST_SENT_PREP, ST_SENT_TONE: return RESP_TONE;
            ST_SENT_VOLT:               return RESP_VOLTAGE;
            ST_SENT_FE:                 return RESP_FRONTEND;
            ST_SENT_START:              return RESP_START;
            ST_SENT_MAST:               return RESP_MASTER;
            ST_SENT_BURST:              return RESP_BURST;
            default:                    return 4'($urandom_range(10));
        endcase
    endfunction

    // Random event: mostly the answer the link waits for, some junk
    function automatic t_item pick_event(bit lock_withheld);
        t_item ev;
        int    roll;
        roll = $urandom_range(99);
        if ($urandom_range(99) < (lock_withheld ? 4 : 15)) begin
            ev.mode         = lock_withheld ? MODE_TICK : 2'($urandom_range(3));
            ev.pids_changed = 1'($urandom_range(1));
            ev.resp_valid   = 1'($urandom_range(1));
            ev.resp_for     = 4'($urandom_range(15));
            ev.resp_bad     = 1'($urandom_range(1));
            ev.resp_status  = 16'($urandom);
            ev.send_ok      = lock_withheld ? 1'b1 : 1'($urandom_range(1));
        end else begin
            ev.mode = MODE_TICK;
            if (!has_tune() && roll < 20)
                ev.mode = MODE_LOAD;
            else if (ln_state == ST_CONN && !ln_flags[FB_DO_TUNE] && roll < 20)
                ev.mode = MODE_START;
            else if (!lock_withheld && roll >= 97)
                ev.mode = MODE_STOP;
            else if (!lock_withheld && roll >= 94)
                ev.mode = MODE_START;
            else if (!lock_withheld && roll >= 92)
                ev.mode = MODE_LOAD;
            ev.pids_changed = ($urandom_range(19) == 0);
            ev.resp_valid   = 1'b1;
            ev.resp_for     = awaited_resp();
            ev.resp_bad     = 1'b0;
            ev.resp_status  = 16'($urandom);
            ev.resp_status[STATUS_LOCK_BIT] = ($urandom_range(99) < 40);
            ev.send_ok      = lock_withheld || ($urandom_range(39) != 0);
        end
        if (lock_withheld)
            ev.resp_status[STATUS_LOCK_BIT] = 1'b0;
        return ev;
    endfunction

    function automatic t_item compose_event(logic [1:0] m, logic pids, logic rv, logic [3:0] rf,
                                            logic rb, logic [15:0] st, logic ok);
        t_item ev;
        ev.mode         = m;
        ev.pids_changed = pids;
        ev.resp_valid   = rv;
        ev.resp_for     = rf;
        ev.resp_bad     = rb;
        ev.resp_status  = st;
        ev.send_ok      = ok;
        return ev;
    endfunction

    // Queue an item for the driver along with its predicted result
    task automatic queue_event(t_item ev);
        t_pending p;
        p.ev  = ev;
        p.res = link_step(ev);
        pending_events.push_back(p);
        outstanding++;
    endtask

    task automatic run_random(int count, bit lock_withheld);
        for (int i = 0; i < count; i++)
            queue_event(pick_event(lock_withheld));
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_CONNECT_ENABLE: cf_enable = data[0];
            CFG_CLIENT_IP:      cf_ip     = data;
            CFG_CLIENT_PORT:    cf_port   = data[15:0];
            CFG_PILOT_SETTING:  cf_pilot  = data[1:0];
            CFG_DISEQC_TYPES:   cf_dtypes = data[7:0];
            default: ;
        endcase
    endtask

    // Registers change only with the link drained
    task automatic load_config(logic en, logic [31:0] ip, logic [15:0] port, logic [1:0] pilot,
                               logic [7:0] dtypes);
        while (outstanding != 0)
            @(posedge i_clk);
        write_reg(CFG_CONNECT_ENABLE, {31'd0, en});
        write_reg(CFG_CLIENT_IP, ip);
        write_reg(CFG_CLIENT_PORT, {16'd0, port});
        write_reg(CFG_PILOT_SETTING, {30'd0, pilot});
        write_reg(CFG_DISEQC_TYPES, {24'd0, dtypes});
    endtask

    // Event driver
    always @(posedge i_clk) begin : drive_events
        logic     next_valid;
        t_pending nxt;
        if (!i_rst_n) begin
            event_ch.valid <= 1'b0;
        end else begin
            next_valid = event_ch.valid;
            if (event_ch.valid && event_ch.ready) begin
                expected_results.push_back(offered_result);
                next_valid = 1'b0;
            end
            if (!next_valid && pending_events.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
                nxt            = pending_events.pop_front();
                offered_result = nxt.res;
                event_ch.mode         <= nxt.ev.mode;
                event_ch.pids_changed <= nxt.ev.pids_changed;
                event_ch.resp_valid   <= nxt.ev.resp_valid;
                event_ch.resp_for     <= nxt.ev.resp_for;
                event_ch.resp_bad     <= nxt.ev.resp_bad;
                event_ch.resp_status  <= nxt.ev.resp_status;
                event_ch.send_ok      <= nxt.ev.send_ok;
                next_valid = 1'b1;
            end
            event_ch.valid <= next_valid;
        end
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            errors++;
        end
    endtask

    // Result monitor and receiver stalls
    always @(posedge i_clk) begin : watch_results
        t_result want;
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ch.ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result item with no event outstanding");
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    outstanding--;
                    check_field("req_valid", want.req_valid, result_ch.req_valid);
                    check_field("req_kind", want.req_kind, result_ch.req_kind);
                    check_field("req_pilot", want.req_pilot, result_ch.req_pilot);
                    check_field("req_slot", want.req_slot, result_ch.req_slot);
                    check_field("reset_link", want.reset_link, result_ch.reset_link);
                    check_field("link_state", want.link_state, result_ch.link_state);
                    check_field("tuned", want.tuned, result_ch.tuned);
                end
            end
            // one long hold-off so the block backs up into its input
            if (!hold_done && results_seen >= 150) begin
                hold_done = 1'b1;
                hold_left = 100;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (event_ch.valid && event_ch.ready) ||
            (result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Stimulus
    initial begin : stimulus
        i_rst_n               = 1'b0;
        event_ch.valid        = 1'b0;
        event_ch.mode         = MODE_TICK;
        event_ch.pids_changed = 1'b0;
        event_ch.resp_valid   = 1'b0;
        event_ch.resp_for     = RESP_CONNECT;
        event_ch.resp_bad     = 1'b0;
        event_ch.resp_status  = '0;
        event_ch.send_ok      = 1'b0;
        result_ch.ready       = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = CFG_CONNECT_ENABLE;
        cfg_ch.data           = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender idles lightly, receiver heavily
        send_idle_pct = 18;
        recv_idle_pct = 50;

        // directed walk: full tune with master and burst slots, lock, failures, cleanup
        load_config(1'b1, 32'hC0A8_0001, 16'd1234, PILOT_AUTO,
                    {DTYPE_END, DTYPE_END, DTYPE_BURST, DTYPE_MASTER});
        queue_event(compose_event(MODE_TICK, 0, 0, RESP_CONNECT, 0, 16'h0000, 1));
        queue_event(compose_event(MODE_LOAD, 0, 0, RESP_CONNECT, 0, 16'h0000, 1));
        queue_event(compose_event(MODE_TICK, 0, 1, RESP_CONNECT, 0, 16'h0000, 1));
        queue_event(compose_event(MODE_TICK, 0, 0, RESP_CONNECT, 0, 16'h0000, 1));
        queue_event(compose_event(MODE_TICK, 0, 1, RESP_STOP, 0, 16'h0000, 1));
        queue_event(compose_event(MODE_TICK, 0, 1, RESP_FILTER, 0, 16'h0000, 1));
        queue_event(compose_event(MODE_TICK, 0, 1, RESP_TONE, 0, 16'h0000, 1));
        queue_event(compose_event(MODE_TICK, 0, 1, RESP_VOLTAGE, 0, 16'h0000, 1));
        queue_event(compose_event(MODE_TICK, 0, 0, RESP_CONNECT, 0, 16'h0000, 1));
        queue_event(compose_event(MODE_TICK, 0, 1, RESP_MASTER, 0, 16'h0000, 1));
        queue_event(compose_event(MODE_TICK, 0, 0, RESP_CONNECT, 0, 16'h0000, 1));
        queue_event(compose_event(MODE_TICK, 0, 1, RESP_BURST, 0, 16'h0000, 1));
        queue_event(compose_event(MODE_TICK, 0, 0, RESP_CONNECT, 0, 16'h0000, 1));
        queue_event(compose_event(MODE_TICK, 0, 0, RESP_CONNECT, 0, 16'h0000, 1));
        queue_event(compose_event(MODE_TICK, 0, 1, RESP_TONE, 0, 16'h0000, 1));
        queue_event(compose_event(MODE_TICK, 0, 1, RESP_FRONTEND, 0, 16'h0000, 1));
        queue_event(compose_event(MODE_TICK, 0, 1, RESP_START, 0, 16'h0000, 1));
        // status without the lock bit, unused response kind, bad response
        queue_event(compose_event(MODE_TICK, 0, 1, RESP_STATUS, 0, 16'hFFEF, 1));
        queue_event(compose_event(MODE_TICK, 0, 1, 4'hF, 0, 16'hFFFF, 1));
        queue_event(compose_event(MODE_TICK, 0, 1, RESP_STATUS, 1, 16'h0010, 1));
        queue_event(compose_event(MODE_TICK, 0, 1, RESP_STATUS, 0, 16'h0010, 1));
        queue_event(compose_event(MODE_TICK, 1, 1, RESP_STATUS, 0, 16'h0000, 1));
        // filter request refused by the transport, then error cleanup
        queue_event(compose_event(MODE_TICK, 0, 0, RESP_CONNECT, 0, 16'h0000, 0));
        queue_event(compose_event(MODE_TICK, 0, 0, RESP_CONNECT, 0, 16'h0000, 1));
        // start and stop while disconnected
        queue_event(compose_event(MODE_START, 0, 0, RESP_CONNECT, 0, 16'h0000, 1));
        queue_event(compose_event(MODE_STOP, 0, 0, RESP_CONNECT, 0, 16'h0000, 1));

        load_config(1'b1, 32'hFFFF_FFFF, 16'hFFFF, 2'd1, 8'h55);
        run_random(150, 1'b0);
        load_config(1'b1, 32'h00FF_FFFF, 16'h0000, 2'd0, 8'hAA);
        run_random(75, 1'b0);
        load_config(1'b0, 32'h0000_0000, 16'h0000, 2'd0, 8'h00);
        run_random(75, 1'b0);

        // roles swapped; lock kept away so the wait budget and pilot retune run out
        send_idle_pct = 50;
        recv_idle_pct = 18;
        load_config(1'b1, {8'($urandom_range(255, 1)), 24'($urandom)},
                    16'($urandom_range(65535, 1)), PILOT_AUTO, 8'h00);
        run_random(1100, 1'b1);

        // no idling
        load_config(1'b1, 32'h0100_0000, 16'd1, 2'd3, 8'hFF);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(75, 1'b0);
        load_config(1'b1, 32'($urandom), 16'($urandom), 2'($urandom_range(3)), 8'($urandom));
        run_random(75, 1'b0);

        while (outstanding != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== tuner_link_control_sequencer.f =====
src/tlcs_pkg.sv
src/tlcs_if.sv
src/tlcs_cfg.sv
src/tlcs_fsm.sv
src/tuner_link_control_sequencer.sv
dv/tuner_link_control_sequencer_tb.sv
